// ===== hdl/tlc_pkg.sv =====
// Shared types and constants for the two-way traffic light controller.
// Used by tlc_cfg_regs and two_way_traffic_light_controller_core; no dependencies.
`default_nettype none

package tlc_pkg;

  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseW      = 3;
  localparam int unsigned TimeW       = 18;
  localparam int unsigned ThreshW     = 10;
  localparam int unsigned HoldW       = 16;
  localparam int unsigned SecW        = 8;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [TimeW-1:0] MsPerSecond = 18'd1000;
  localparam logic [TimeW-1:0] ElapsedMax  = 18'd262143;

  localparam logic [PhaseW-1:0] PhaseGreenA  = 3'd0;
  localparam logic [PhaseW-1:0] PhaseAmberA  = 3'd1;
  localparam logic [PhaseW-1:0] PhaseAllRedA = 3'd2;
  localparam logic [PhaseW-1:0] PhaseGreenB  = 3'd3;
  localparam logic [PhaseW-1:0] PhaseAmberB  = 3'd4;
  localparam logic [PhaseW-1:0] PhaseAllRedB = 3'd5;

  localparam logic [CfgIdxW-1:0] RegLdrThreshold = 4'd0;
  localparam logic [CfgIdxW-1:0] RegDemandHold   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegDayGreenA    = 4'd2;
  localparam logic [CfgIdxW-1:0] RegDayGreenB    = 4'd3;
  localparam logic [CfgIdxW-1:0] RegNightGreenA  = 4'd4;
  localparam logic [CfgIdxW-1:0] RegNightGreenB  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegAmber        = 4'd6;
  localparam logic [CfgIdxW-1:0] RegAllRed       = 4'd7;

  typedef struct packed {
    logic [ThreshW-1:0] ldr_threshold;
    logic [HoldW-1:0]   demand_hold_ms;
    logic [SecW-1:0]    day_green_a;
    logic [SecW-1:0]    day_green_b;
    logic [SecW-1:0]    night_green_a;
    logic [SecW-1:0]    night_green_b;
    logic [SecW-1:0]    amber_seconds;
    logic [SecW-1:0]    all_red_seconds;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    ldr_threshold:   10'd50,
    demand_hold_ms:  16'd2000,
    day_green_a:     8'd10,
    day_green_b:     8'd10,
    night_green_a:   8'd30,
    night_green_b:   8'd20,
    amber_seconds:   8'd2,
    all_red_seconds: 8'd2
  };

  // lamps of one road: red, amber, green from bit 0 up
  typedef struct packed {
    logic green;
    logic amber;
    logic red;
  } lamps_t;

  localparam lamps_t LampRed   = '{green: 1'b0, amber: 1'b0, red: 1'b1};
  localparam lamps_t LampAmber = '{green: 1'b0, amber: 1'b1, red: 1'b0};
  localparam lamps_t LampGreen = '{green: 1'b1, amber: 1'b0, red: 1'b0};

  function automatic lamps_t lamps_a(input logic [PhaseW-1:0] ph);
    lamps_t l;
    case (ph)
      PhaseGreenA: l = LampGreen;
      PhaseAmberA: l = LampAmber;
      default:     l = LampRed;
    endcase
    return l;
  endfunction

  function automatic lamps_t lamps_b(input logic [PhaseW-1:0] ph);
    lamps_t l;
    case (ph)
      PhaseGreenB: l = LampGreen;
      PhaseAmberB: l = LampAmber;
      default:     l = LampRed;
    endcase
    return l;
  endfunction

  function automatic logic [PhaseW-1:0] next_phase(input logic [PhaseW-1:0] ph);
    logic [PhaseW-1:0] n;
    if (ph >= PhaseAllRedB) begin
      n = PhaseGreenA;
    end else begin
      n = ph + 3'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/two_way_traffic_light_controller_core.sv =====
// Top level of the two-way traffic light controller: input stage, phase logic, output stage.
// Depends on tlc_pkg and tlc_cfg_regs.
//
// One input transfer is one millisecond tick and yields exactly one output transfer with the
// lamps of the phase in force at that tick. A tick passes through the input register and then
// the output register before its result can transfer from the output side;
// both sides are pipelined and a new tick is taken every cycle while the output side keeps up.
// The phase timer, the demand cut and the day/night choice all update in the single step
// between the two registers. Configuration writes are taken at any time and must only be
// issued while no tick is in flight.
`default_nettype none

module two_way_traffic_light_controller_core #(
  parameter int unsigned ADC_BITS = 10
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // slave side, tdata: ldr_level, demand_a, demand_b
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [((ADC_BITS + 2 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // master side, tdata: a_red, a_amber, a_green, b_red, b_amber, b_green, phase_shown[3],
  // is_day
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [((6 + tlc_pkg::PhaseW + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [tlc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [tlc_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned OutBits = 6 + tlc_pkg::PhaseW + 1;
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;
  localparam int unsigned CmpW    = (ADC_BITS > tlc_pkg::ThreshW) ? ADC_BITS : tlc_pkg::ThreshW;
  localparam logic [CmpW-1:0] AdcMask = CmpW'((64'd1 << ADC_BITS) - 64'd1);

  tlc_pkg::cfg_t cfg;

  tlc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i & cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  assign cfg_ready_o = 1'b1;

  logic                       in_valid_q;
  logic [ADC_BITS-1:0]        level_q;
  logic                       dem_a_q, dem_b_q;
  logic                       out_valid_q;
  logic [OutBits-1:0]         out_data_q, out_data_d;
  logic [tlc_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [tlc_pkg::TimeW-1:0]  elapsed_q, elapsed_d;
  logic [tlc_pkg::TimeW-1:0]  dur_q, dur_d;

  logic                       out_free, step, in_take;
  logic                       is_day, cut, adv;
  tlc_pkg::lamps_t            la, lb;
  logic [tlc_pkg::TimeW-1:0]  hold_ext, dur_eff;
  logic [tlc_pkg::PhaseW-1:0] ph_next;
  logic [tlc_pkg::SecW-1:0]   secs;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      level_q <= s_axis_tdata[ADC_BITS-1:0];
      dem_a_q <= s_axis_tdata[ADC_BITS];
      dem_b_q <= s_axis_tdata[ADC_BITS+1];
    end
  end

  always_comb begin
    la       = tlc_pkg::lamps_a(phase_q);
    lb       = tlc_pkg::lamps_b(phase_q);
    is_day   = CmpW'(level_q) > (CmpW'(cfg.ldr_threshold) & AdcMask);
    hold_ext = tlc_pkg::TimeW'(cfg.demand_hold_ms);
    cut      = (dem_a_q != dem_b_q) && (dur_q > hold_ext) &&
               ((dem_a_q && lb.green) || (dem_b_q && la.green));
    dur_eff  = cut ? hold_ext : dur_q;
    adv      = elapsed_q >= dur_eff;
    ph_next  = tlc_pkg::next_phase(phase_q);
    case (ph_next)
      tlc_pkg::PhaseGreenA: secs = is_day ? cfg.day_green_a : cfg.night_green_a;
      tlc_pkg::PhaseGreenB: secs = is_day ? cfg.day_green_b : cfg.night_green_b;
      tlc_pkg::PhaseAmberA,
      tlc_pkg::PhaseAmberB: secs = cfg.amber_seconds;
      default:              secs = cfg.all_red_seconds;
    endcase

    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    dur_d     = dur_eff;
    if (adv) begin
      phase_d   = ph_next;
      dur_d     = tlc_pkg::TimeW'(secs) * tlc_pkg::MsPerSecond;
      elapsed_d = tlc_pkg::TimeW'(1);
    end else if (elapsed_q < tlc_pkg::ElapsedMax) begin
      elapsed_d = elapsed_q + tlc_pkg::TimeW'(1);
    end

    out_data_d = {is_day, phase_q, lb.green, lb.amber, lb.red, la.green, la.amber, la.red};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tlc_pkg::PhaseGreenA;
      elapsed_q   <= '0;
      dur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q   <= phase_d;
        elapsed_q <= elapsed_d;
        dur_q     <= dur_d;
      end
      if (out_free) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_data_q);

`ifndef NO_ASSERTIONS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= tlc_pkg::PhaseAllRedB)
    else $error("phase register out of range");

  a_phase_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && adv |=> phase_q == tlc_pkg::next_phase($past(phase_q)) && elapsed_q == 18'd1)
    else $error("phase did not advance in order");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(phase_q) && $stable(elapsed_q) && $stable(dur_q))
    else $error("timer state moved without a tick");

  a_one_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(la.green && lb.green) && $onehot(la) && $onehot(lb))
    else $error("conflicting lamps");
`endif

endmodule

`default_nettype wire

// ===== hdl/tlc_cfg_regs.sv =====
// Configuration register file of the traffic light controller.
// Depends on tlc_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module tlc_cfg_regs (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         wr_en_i,
  input  wire  [tlc_pkg::CfgIdxW-1:0] wr_idx_i,
  input  wire  [tlc_pkg::CfgDataW-1:0] wr_data_i,
  output tlc_pkg::cfg_t               cfg_o
);

  tlc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        tlc_pkg::RegLdrThreshold: cfg_d.ldr_threshold   = wr_data_i[tlc_pkg::ThreshW-1:0];
        tlc_pkg::RegDemandHold:   cfg_d.demand_hold_ms  = wr_data_i[tlc_pkg::HoldW-1:0];
        tlc_pkg::RegDayGreenA:    cfg_d.day_green_a     = wr_data_i[tlc_pkg::SecW-1:0];
        tlc_pkg::RegDayGreenB:    cfg_d.day_green_b     = wr_data_i[tlc_pkg::SecW-1:0];
        tlc_pkg::RegNightGreenA:  cfg_d.night_green_a   = wr_data_i[tlc_pkg::SecW-1:0];
        tlc_pkg::RegNightGreenB:  cfg_d.night_green_b   = wr_data_i[tlc_pkg::SecW-1:0];
        tlc_pkg::RegAmber:        cfg_d.amber_seconds   = wr_data_i[tlc_pkg::SecW-1:0];
        tlc_pkg::RegAllRed:       cfg_d.all_red_seconds = wr_data_i[tlc_pkg::SecW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tlc_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
